### hw/rtl/pet_pkg.sv
`timescale 1ns / 1ps

package pet_pkg;

  // Most expiry results reported for one tick
  localparam int unsigned MaxResults = 8;

  typedef enum logic [2:0] {
    K_TICK       = 3'd0,
    K_ADD        = 3'd1,
    K_DELETE     = 3'd2,
    K_START      = 3'd3,
    K_STOP       = 3'd4,
    K_RELOAD     = 3'd5,
    K_SET_PERIOD = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_EXPIRY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_ADD,
    S_CMD_WR,
    S_FLUSH
  } state_e;

  // One timer slot as held in the state memory
  typedef struct packed {
    logic        running;
    logic [15:0] reload;
    logic [15:0] ticks;
    logic [15:0] fires;
  } timer_entry_t;

  // One result item
  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic [15:0] fires;
  } result_t;

endpackage

### hw/rtl/periodic_event_timer_bank.sv
`timescale 1ns / 1ps
// Path from accept to result registered: delete or a command on a free slot through S_FLUSH;
//   start/stop/reload/set through S_CMD_WR and S_FLUSH; add through S_ADD (one allocation mark a cycle) and S_FLUSH.
// Tick: walks the timer memory one slot a cycle, then S_FLUSH for the last
//   expiry when any timer fired; a stalled output with a result held pauses the walk.
// One item at a time: the next is taken the cycle after the last result is registered
//   (after the walk for a tick with no expiry); reset (async, active low) clears marks.
module periodic_event_timer_bank import pet_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  slot_i,
  input  logic [15:0] period_i,
  input  logic        run_at_once_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  slot_out_o,
  output logic [15:0] fire_count_o,
  output logic        last_o
);

  localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned EW = IW + 3;
  localparam int unsigned NW = $clog2(MaxResults + 1);

  state_e                 state_q, state_d;
  logic [TIMER_SLOTS-1:0] in_use_q, in_use_d;

  // latched command
  kind_e       kind_q;
  logic [IW-1:0] slot_q;
  logic [2:0]  slot_raw_q;
  logic [15:0] period_q;
  logic        at_once_q;
  logic        cmd_load;

  // walk pointers: read stage and modify stage
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_more_q, rd_more_d;
  logic          st_valid_q, st_valid_d;
  logic [IW-1:0] st_idx_q, st_idx_d;
  logic [NW-1:0] n_q, n_d;

  // held result and output register
  logic    pend_valid_q, pend_valid_d;
  result_t pend_q, pend_d;
  logic    out_valid_q;
  result_t out_q;
  logic    out_last_q;
  logic    push, push_last;
  result_t push_res;
  logic    out_free;

  // timer memory
  timer_entry_t  timer_mem [TIMER_SLOTS];
  timer_entry_t  rdata_q;
  logic          mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  timer_entry_t  mem_wdata;

  // slot decode
  logic [EW-1:0] slot_ext, st_ext, rd_ext;
  logic          slot_ok;
  logic [IW-1:0] slot_idx;

  // tick datapath
  logic [15:0] ticks_dec, fires_inc;
  logic        stage_hit, expire, report, blocked;

  assign slot_ext = EW'(slot_i);
  assign slot_ok  = slot_ext < EW'(TIMER_SLOTS);
  assign slot_idx = slot_ext[IW-1:0];
  assign st_ext   = EW'(st_idx_q);
  assign rd_ext   = EW'(rd_idx_q);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign ticks_dec  = rdata_q.ticks - 16'd1;
  assign fires_inc  = rdata_q.fires + 16'd1;
  assign stage_hit  = st_valid_q && in_use_q[st_idx_q] && rdata_q.running;
  assign expire     = stage_hit && (ticks_dec == 16'd0);
  assign report     = expire && (n_q < NW'(MaxResults));
  // a second expiry needs the held one moved out first
  assign blocked    = report && pend_valid_q && !out_free;

  assign in_stall_o = (state_q != S_IDLE);

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    in_use_d     = in_use_q;
    rd_idx_d     = rd_idx_q;
    rd_more_d    = rd_more_q;
    st_valid_d   = st_valid_q;
    st_idx_d     = st_idx_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    push         = 1'b0;
    push_res     = pend_q;
    push_last    = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = rd_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = st_idx_q;
    mem_wdata    = rdata_q;
    cmd_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_load = 1'b1;
          case (kind_e'(kind_i))
            K_TICK: begin
              state_d    = S_TICK;
              rd_idx_d   = '0;
              rd_more_d  = 1'b1;
              st_valid_d = 1'b0;
              n_d        = '0;
            end
            K_ADD: begin
              state_d  = S_ADD;
              rd_idx_d = '0;
            end
            K_DELETE, K_START, K_STOP, K_RELOAD, K_SET_PERIOD: begin
              if (!slot_ok || !in_use_q[slot_idx]) begin
                pend_d       = '{status: ST_EMPTY, slot: slot_i, fires: 16'd0};
                pend_valid_d = 1'b1;
                state_d      = S_FLUSH;
              end else if (kind_e'(kind_i) == K_DELETE) begin
                in_use_d[slot_idx] = 1'b0;
                pend_d       = '{status: ST_OK, slot: slot_i, fires: 16'd0};
                pend_valid_d = 1'b1;
                state_d      = S_FLUSH;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = slot_idx;
                state_d   = S_CMD_WR;
              end
            end
            default: ;  // unused kind: no result
          endcase
        end
      end

      // read slot k while slot k-1 is modified and written back
      S_TICK: begin
        if (!blocked) begin
          if (stage_hit) begin
            mem_we    = 1'b1;
            mem_waddr = st_idx_q;
            if (expire) begin
              mem_wdata.ticks = rdata_q.reload;
              mem_wdata.fires = fires_inc;
            end else begin
              mem_wdata.ticks = ticks_dec;
            end
          end
          if (report) begin
            n_d = n_q + NW'(1);
            if (pend_valid_q) begin
              push      = 1'b1;
              push_res  = pend_q;
              push_last = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_d = '{status: ST_EXPIRY, slot: st_ext[2:0], fires: fires_inc};
          end
          if (rd_more_q) begin
            mem_re     = 1'b1;
            mem_raddr  = rd_idx_q;
            st_valid_d = 1'b1;
            st_idx_d   = rd_idx_q;
            rd_idx_d   = rd_idx_q + IW'(1);
            rd_more_d  = (rd_idx_q != IW'(TIMER_SLOTS - 1));
          end else begin
            st_valid_d = 1'b0;
            if (!st_valid_q) begin
              state_d = pend_valid_q ? S_FLUSH : S_IDLE;
            end
          end
        end
      end

      // lowest free slot, one mark a cycle
      S_ADD: begin
        if (!in_use_q[rd_idx_q]) begin
          in_use_d[rd_idx_q] = 1'b1;
          mem_we       = 1'b1;
          mem_waddr    = rd_idx_q;
          mem_wdata    = '{running: at_once_q, reload: period_q, ticks: period_q,
                           fires: 16'd0};
          pend_d       = '{status: ST_OK, slot: rd_ext[2:0], fires: 16'd0};
          pend_valid_d = 1'b1;
          state_d      = S_FLUSH;
        end else if (rd_idx_q == IW'(TIMER_SLOTS - 1)) begin
          pend_d       = '{status: ST_FULL, slot: 3'd0, fires: 16'd0};
          pend_valid_d = 1'b1;
          state_d      = S_FLUSH;
        end else begin
          rd_idx_d = rd_idx_q + IW'(1);
        end
      end

      // modify the entry read at accept and write it back
      S_CMD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = slot_q;
        unique case (kind_q)
          K_START: begin
            mem_wdata.ticks   = rdata_q.reload;
            mem_wdata.fires   = 16'd0;
            mem_wdata.running = 1'b1;
          end
          K_STOP:   mem_wdata.running = 1'b0;
          K_RELOAD: mem_wdata.ticks   = rdata_q.reload;
          default:  mem_wdata.reload  = period_q;
        endcase
        pend_d       = '{status: ST_OK, slot: slot_raw_q, fires: 16'd0};
        pend_valid_d = 1'b1;
        state_d      = S_FLUSH;
      end

      // final result of the item
      S_FLUSH: begin
        if (out_free) begin
          push         = 1'b1;
          push_res     = pend_q;
          push_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_use_q     <= '0;
      rd_more_q    <= 1'b0;
      st_valid_q   <= 1'b0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      in_use_q     <= in_use_d;
      rd_more_q    <= rd_more_d;
      st_valid_q   <= st_valid_d;
      n_q          <= n_d;
      pend_valid_q <= pend_valid_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    st_idx_q <= st_idx_d;
    pend_q   <= pend_d;
    if (cmd_load) begin
      kind_q     <= kind_e'(kind_i);
      slot_q     <= slot_idx;
      slot_raw_q <= slot_i;
      period_q   <= period_i;
      at_once_q  <= run_at_once_i;
    end
    if (push) begin
      out_q      <= push_res;
      out_last_q <= push_last;
    end
  end

  // timer memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      timer_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= timer_mem[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign slot_out_o   = out_q.slot;
  assign fire_count_o = out_q.fires;
  assign last_o       = out_last_q;

endmodule

### hw/rtl/pet_checker.sv
`timescale 1ns / 1ps
module pet_checker import pet_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [2:0]  slot_out_o,
  input logic [15:0] fire_count_o,
  input logic        last_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(slot_out_o) && $stable(fire_count_o) && $stable(last_o))
    else $error("stalled result changed");

  // only expiries come in groups; commands give a single result
  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_EXPIRY) |-> last_o && (fire_count_o == 16'd0))
    else $error("command result not single or carries a count");

  // a full bank reports slot zero
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (slot_out_o == 3'd0))
    else $error("no-free-slot result with nonzero slot");

  // more results of the same item follow only after an expiry
  a_mid_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> (status_o == ST_EXPIRY))
    else $error("non-final result that is not an expiry");

endmodule

bind periodic_event_timer_bank pet_checker u_pet_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps

module tb import pet_pkg::*;;

  localparam int unsigned TIMER_SLOTS = 8;
  localparam logic [2:0]  KIND_UNUSED = 3'd7;
  // Cycles to let a tick with no expiry finish walking the bank
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 98;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic [15:0] fires;
    logic        last;
  } timer_result_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [15:0] period;
    logic        run;
    logic        typed;   // status/slot below are the expected result
    status_e     status;
    logic [2:0]  slot_out;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 25;

  // Directed walk: empty bank, fill it, overflow, expiries, every command
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{K_TICK,       3'd0, 16'd0,     1'b0, 1'b0, ST_OK,    3'd0},  // tick on empty bank
    '{K_DELETE,     3'd7, 16'd0,     1'b0, 1'b1, ST_EMPTY, 3'd7},
    '{K_SET_PERIOD, 3'd6, 16'hFFFF,  1'b1, 1'b1, ST_EMPTY, 3'd6},
    '{K_ADD,        3'd0, 16'd1,     1'b1, 1'b1, ST_OK,    3'd0},
    '{K_ADD,        3'd7, 16'd0,     1'b0, 1'b1, ST_OK,    3'd1},  // period 0 wraps
    '{K_ADD,        3'd0, 16'hFFFF,  1'b1, 1'b1, ST_OK,    3'd2},
    '{K_ADD,        3'd0, 16'd2,     1'b1, 1'b1, ST_OK,    3'd3},
    '{K_ADD,        3'd0, 16'd1,     1'b1, 1'b1, ST_OK,    3'd4},
    '{K_ADD,        3'd0, 16'd1,     1'b1, 1'b1, ST_OK,    3'd5},
    '{K_ADD,        3'd0, 16'd1,     1'b1, 1'b1, ST_OK,    3'd6},
    '{K_ADD,        3'd0, 16'd1,     1'b1, 1'b1, ST_OK,    3'd7},
    '{K_ADD,        3'd5, 16'd3,     1'b1, 1'b1, ST_FULL,  3'd0},  // bank full
    '{K_TICK,       3'd0, 16'd0,     1'b0, 1'b0, ST_OK,    3'd0},
    '{K_TICK,       3'd2, 16'd9,     1'b1, 1'b0, ST_OK,    3'd0},
    '{KIND_UNUSED,  3'd2, 16'd7,     1'b1, 1'b0, ST_OK,    3'd0},  // ignored
    '{K_STOP,       3'd0, 16'd0,     1'b0, 1'b1, ST_OK,    3'd0},
    '{K_SET_PERIOD, 3'd1, 16'd1,     1'b0, 1'b1, ST_OK,    3'd1},
    '{K_START,      3'd1, 16'd0,     1'b0, 1'b1, ST_OK,    3'd1},
    '{K_SET_PERIOD, 3'd2, 16'd1,     1'b0, 1'b1, ST_OK,    3'd2},
    '{K_RELOAD,     3'd2, 16'd0,     1'b0, 1'b1, ST_OK,    3'd2},
    '{K_START,      3'd0, 16'd0,     1'b0, 1'b1, ST_OK,    3'd0},
    '{K_TICK,       3'd0, 16'd0,     1'b0, 1'b0, ST_OK,    3'd0},
    '{K_DELETE,     3'd4, 16'd0,     1'b0, 1'b1, ST_OK,    3'd4},
    '{K_ADD,        3'd3, 16'h8000,  1'b0, 1'b1, ST_OK,    3'd4},  // reuses lowest free
    '{K_TICK,       3'd0, 16'd0,     1'b0, 1'b0, ST_OK,    3'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = 3'd0;
  logic [2:0]  slot_i = 3'd0;
  logic [15:0] period_i = 16'd0;
  logic        run_at_once_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [2:0]  slot_out_o;
  logic [15:0] fire_count_o;
  logic        last_o;

  // Timer bank mirror
  bit          slot_used    [TIMER_SLOTS];
  bit          slot_running [TIMER_SLOTS];
  logic [15:0] slot_reload  [TIMER_SLOTS];
  logic [15:0] slot_left    [TIMER_SLOTS];
  logic [15:0] slot_fires   [TIMER_SLOTS];

  timer_result_t result_queue [$];
  timer_result_t want;
  int unsigned   errors = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   sender_idle_pct = 8;
  int unsigned   recv_idle_pct = 71;
  int unsigned   hold_ticket = 0;
  int unsigned   hold_taken = 0;
  int unsigned   hold_left = 0;

  periodic_event_timer_bank #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .slot_i,
    .period_i,
    .run_at_once_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .slot_out_o,
    .fire_count_o,
    .last_o
  );

  always #4 clk_i = ~clk_i;

  // Apply one item to the mirror and queue the results it causes
  function automatic void predict_timer_bank(input logic [2:0] kind, input logic [2:0] slot,
                                             input logic [15:0] period, input logic run);
    timer_result_t held;
    bit            have_held;
    int            n;
    int            free_slot;
    have_held = 1'b0;
    n = 0;
    free_slot = -1;
    case (kind)
      K_TICK: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (slot_used[i] && slot_running[i]) begin
            slot_left[i] = slot_left[i] - 16'd1;
            if (slot_left[i] == 16'd0) begin
              slot_fires[i] = slot_fires[i] + 16'd1;
              if (n < MaxResults) begin
                if (have_held) result_queue.push_back(held);
                held = '{ST_EXPIRY, 3'(i), slot_fires[i], 1'b0};
                have_held = 1'b1;
                n++;
              end
              slot_left[i] = slot_reload[i];
            end
          end
        end
      end
      K_ADD: begin
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
          if (!slot_used[i]) free_slot = i;
        if (free_slot >= 0) begin
          slot_used[free_slot] = 1'b1;
          slot_reload[free_slot] = period;
          slot_left[free_slot] = period;
          slot_fires[free_slot] = 16'd0;
          slot_running[free_slot] = run;
          held = '{ST_OK, 3'(free_slot), 16'd0, 1'b0};
        end else begin
          held = '{ST_FULL, 3'd0, 16'd0, 1'b0};
        end
        have_held = 1'b1;
      end
      K_DELETE, K_START, K_STOP, K_RELOAD, K_SET_PERIOD: begin
        if (slot >= TIMER_SLOTS || !slot_used[slot]) begin
          held = '{ST_EMPTY, slot, 16'd0, 1'b0};
        end else begin
          case (kind)
            K_DELETE: slot_used[slot] = 1'b0;
            K_START: begin
              slot_left[slot] = slot_reload[slot];
              slot_fires[slot] = 16'd0;
              slot_running[slot] = 1'b1;
            end
            K_STOP:   slot_running[slot] = 1'b0;
            K_RELOAD: slot_left[slot] = slot_reload[slot];
            default:  slot_reload[slot] = period;
          endcase
          held = '{ST_OK, slot, 16'd0, 1'b0};
        end
        have_held = 1'b1;
      end
      default: ;  // unused kind: no effect, no result
    endcase
    if (have_held) begin
      held.last = 1'b1;
      result_queue.push_back(held);
    end
  endfunction

  // Offer one item, wait for it to be taken, then record what it should cause.
  // Called and returns at a falling edge.
  task automatic offer_item(input logic [2:0] kind, input logic [2:0] slot,
                            input logic [15:0] period, input logic run,
                            input logic typed, input status_e status, input logic [2:0] slot_out);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = kind;
    slot_i = slot;
    period_i = period;
    run_at_once_i = run;
    do @(posedge clk_i); while (in_stall_o);
    predict_timer_bank(kind, slot, period, run);
    if (typed) begin
      void'(result_queue.pop_back());
      result_queue.push_back('{status, slot_out, 16'd0, 1'b1});
    end
    @(negedge clk_i);
  endtask

  // Sender pause: everything out, then let a silent tick finish
  task automatic wait_for_results();
    in_valid_i = 1'b0;
    while (result_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Random item: a tick or a command on a random slot, mostly with short periods
  task automatic offer_random_item(output bit counted);
    logic [2:0]  kind;
    logic [15:0] period;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45)      kind = K_TICK;
    else if (roll < 60) kind = K_ADD;
    else if (roll < 68) kind = K_DELETE;
    else if (roll < 76) kind = K_START;
    else if (roll < 82) kind = K_STOP;
    else if (roll < 88) kind = K_RELOAD;
    else if (roll < 97) kind = K_SET_PERIOD;
    else                kind = KIND_UNUSED;
    roll = $urandom_range(99);
    if (roll < 80)      period = 16'($urandom_range(6, 1));
    else if (roll < 92) period = 16'($urandom);
    else if (roll < 96) period = 16'd0;
    else                period = 16'hFFFF;
    offer_item(kind, 3'($urandom_range(7)), period, 1'($urandom_range(1)),
               1'b0, ST_OK, 3'd0);
    counted = (kind != KIND_UNUSED);
  endtask

  // Result side: random stall, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_ticket != hold_taken) begin
      hold_taken = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  // Compare each delivered item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_queue.size() == 0) begin
        $error("unexpected item: status %0d slot %0d fire_count %0d last %0d",
               status_o, slot_out_o, fire_count_o, last_o);
        errors++;
      end else begin
        want = result_queue.pop_front();
        check_field("status", want.status, status_o);
        check_field("slot_out", want.slot, slot_out_o);
        check_field("fire_count", want.fires, fire_count_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    bit          counted;
    int unsigned sent;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r])
      offer_item(directed_rows[r].kind, directed_rows[r].slot, directed_rows[r].period,
                 directed_rows[r].run, directed_rows[r].typed, directed_rows[r].status,
                 directed_rows[r].slot_out);
    wait_for_results();

    // Three idling profiles; the first also holds the result side off for a while
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 8 : 0;
      if (phase == 0) hold_ticket = hold_ticket + 1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        offer_random_item(counted);
        if (counted) sent++;
      end
      wait_for_results();
    end

    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
